[hdl/fsaf_pkg.sv]
package fsaf_pkg;

    localparam int CH_FIELD_W = 2;
    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 8;
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int DIV_W      = 26;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int FRAME_LEN  = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 8'd24;
    localparam logic [WORD_W-1:0] SUPPLY_RESET = 16'd3300;
    localparam logic [WORD_W-1:0] HEADER_RESET = 16'd65534;
    localparam logic [9:0]        MV_SCALE     = 10'd1000;
    localparam logic [WORD_W-1:0] FORCE_MAX    = 16'hFFFF;

    typedef struct packed {
        logic                  opcode;
        logic [CH_FIELD_W-1:0] channel;
        logic [SAMPLE_W-1:0]   sample;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
        logic              saturated;
    } tx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] force_gain;
        logic [WORD_W-1:0] supply_millivolts;
        logic [WORD_W-1:0] header_word;
    } cfg_t;

    typedef enum logic {
        CMD_FORCE,
        CMD_FRAME
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [CH_FIELD_W-1:0] channel;
        logic [DIV_W-1:0]      sum;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCALE,
        BK_RATIO,
        BK_DIV,
        BK_GAIN,
        BK_FRAME
    } back_state_t;

endpackage

[hdl/force_sensor_average_and_frame_unit.sv]
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_ready    | item_data (opcode, channel, sample)
// tx       | out       | tx_valid / tx_ready        | tx_data (frame_byte, last_byte, saturated)
// cfg      | in        | cfg_we, no wait            | cfg_index, cfg_data
//
// A sample transfer is taken by the front end while the queue has room; when it completes a
// block, the back end works through scale, ratio, division and gain steps, the division
// being one 26-step serial division (a zero supply skips the division).
// A tick produces eight byte transfers, one per cycle while tx_ready stays high.
// A two-entry command queue lets the front end keep taking items while the back end works.
// Reset clears sums, tallies, forces, clip flags and the registers to their defaults.
module force_sensor_average_and_frame_unit #(
    parameter int NUM_CHANNELS = 4,
    parameter int AVG_COUNT    = 10,
    parameter int ADC_BITS     = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  fsaf_pkg::item_t                item_data,
    output logic                           tx_valid,
    input  logic                           tx_ready,
    output fsaf_pkg::tx_t                  tx_data,
    input  logic                           cfg_we,
    input  logic [fsaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsaf_pkg::WORD_W-1:0]    cfg_data
);
    import fsaf_pkg::*;

    cfg_t     cfg_reg;
    logic     push;
    cmd_t     push_cmd;
    logic     q_full;
    logic     q_empty;
    logic     pop;
    cmd_t     pop_cmd;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_gain        <= GAIN_RESET;
            cfg_reg.supply_millivolts <= SUPPLY_RESET;
            cfg_reg.header_word       <= HEADER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORCE_GAIN:  cfg_reg.force_gain        <= cfg_data[GAIN_W-1:0];
                REG_SUPPLY_MV:   cfg_reg.supply_millivolts <= cfg_data;
                REG_HEADER_WORD: cfg_reg.header_word       <= cfg_data;
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    fsaf_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AVG_COUNT    (AVG_COUNT),
        .ADC_BITS     (ADC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    fsaf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    fsaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fsaf_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AVG_COUNT    (AVG_COUNT),
        .ADC_BITS     (ADC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .cmd      (pop_cmd),
        .pop      (pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .tx_valid (tx_valid),
        .tx_ready (tx_ready),
        .tx_data  (tx_data)
    );

endmodule

[hdl/fsaf_front.sv]
module fsaf_front #(
    parameter int NUM_CHANNELS = 4,
    parameter int AVG_COUNT    = 10,
    parameter int ADC_BITS     = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  fsaf_pkg::item_t item_data,
    output logic           push,
    output fsaf_pkg::cmd_t push_cmd,
    input  logic           q_full
);
    import fsaf_pkg::*;

    localparam int CH_W    = $clog2(NUM_CHANNELS);
    localparam int TALLY_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
    localparam int SUM_W   = ADC_BITS + $clog2(AVG_COUNT + 1);
    localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((32'd1 << ADC_BITS) - 32'd1);

    logic [SUM_W-1:0]   sum_reg   [NUM_CHANNELS];
    logic [TALLY_W-1:0] tally_reg [NUM_CHANNELS];

    logic               accept;
    logic               is_tick;
    logic               ch_ok;
    logic [CH_W-1:0]    idx;
    logic [SUM_W-1:0]   sum_next;
    logic [TALLY_W:0]   tally_next;
    logic               block_done;

    assign item_ready = !q_full;

    always_comb
    begin
        accept     = item_valid && item_ready;
        is_tick    = (item_data.opcode == OP_TICK);
        ch_ok      = (item_data.channel != '0) && (int'(item_data.channel) < NUM_CHANNELS);
        idx        = CH_W'(item_data.channel);
        sum_next   = sum_reg[idx] + SUM_W'(item_data.sample & SMP_MASK);
        tally_next = (TALLY_W + 1)'(tally_reg[idx]) + 1'b1;
        block_done = (tally_next >= (TALLY_W + 1)'(AVG_COUNT));

        push             = accept && (is_tick || (ch_ok && block_done));
        push_cmd.kind    = is_tick ? CMD_FRAME : CMD_FORCE;
        push_cmd.channel = item_data.channel;
        push_cmd.sum     = DIV_W'(sum_next);
    end

    // A completed block restarts that channel's sum; the total travels in the command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i]   <= '0;
                tally_reg[i] <= '0;
            end
        end
        else if (accept && !is_tick && ch_ok)
        begin
            if (block_done)
            begin
                sum_reg[idx]   <= '0;
                tally_reg[idx] <= '0;
            end
            else
            begin
                sum_reg[idx]   <= sum_next;
                tally_reg[idx] <= TALLY_W'(tally_next);
            end
        end
    end

endmodule

[hdl/fsaf_queue.sv]
module fsaf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fsaf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output fsaf_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import fsaf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/fsaf_div.sv]
module fsaf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fsaf_pkg::div_req_t req,
    output fsaf_pkg::div_rsp_t rsp
);
    import fsaf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WORD_W-1:0]  rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [WORD_W-1:0]  den_reg;

    logic [WORD_W:0]    rem_shift;
    logic               ge;
    logic [WORD_W-1:0]  rem_next;

    // Restoring division: the dividend shifts out of quo_reg as quotient bits shift in.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        ge        = (rem_shift >= {1'b0, den_reg});
        rem_next  = ge ? WORD_W'(rem_shift - {1'b0, den_reg}) : rem_shift[WORD_W-1:0];
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

endmodule

[hdl/fsaf_back.sv]
module fsaf_back #(
    parameter int NUM_CHANNELS = 4,
    parameter int AVG_COUNT    = 10,
    parameter int ADC_BITS     = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fsaf_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  fsaf_pkg::cmd_t     cmd,
    output logic               pop,
    output fsaf_pkg::div_req_t div_req,
    input  fsaf_pkg::div_rsp_t div_rsp,
    output logic               tx_valid,
    input  logic               tx_ready,
    output fsaf_pkg::tx_t      tx_data
);
    import fsaf_pkg::*;

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int F_W       = GAIN_W + DIV_W;
    localparam int SUM_W     = ADC_BITS + $clog2(AVG_COUNT + 1);
    localparam int AVG_SHIFT = SUM_W + $clog2(AVG_COUNT);
    localparam int RECIP_W   = SUM_W + 2;
    localparam int AVG_PW    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((64'd1 << AVG_SHIFT) / 64'(AVG_COUNT) + 64'd1);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CH_W-1:0]    ch_reg;
    logic [WORD_W-1:0]  avg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIV_W-1:0]   quot_reg;
    logic [WORD_W-1:0]  force_reg [NUM_CHANNELS];
    logic               clip_reg  [NUM_CHANNELS];
    logic [IDX_W-1:0]   byte_idx_reg;
    logic               tx_valid_reg;
    tx_t                tx_reg;

    logic [AVG_PW-1:0]  avg_prod;
    logic [WORD_W-1:0]  mv;
    logic [WORD_W-1:0]  den;
    logic [DIV_W-1:0]   ratio_num;
    logic [F_W-1:0]     force_full;
    logic               force_sat;
    logic               load;
    logic [1:0]         word_sel;
    logic [WORD_W-1:0]  word_val;
    logic               word_sat;
    tx_t                tx_next;

    // The block average is a multiply by the rounded-up reciprocal of the block length,
    // which gives the truncated quotient for every sum a block can reach.
    always_comb
    begin
        avg_prod   = AVG_PW'(cmd.sum[SUM_W-1:0]) * AVG_PW'(AVG_RECIP);
        mv         = WORD_W'(prod_reg >> ADC_BITS);
        den        = cfg.supply_millivolts - mv;
        ratio_num  = DIV_W'(DIV_W'(mv) * DIV_W'(MV_SCALE));
        force_full = F_W'(cfg.force_gain) * F_W'(quot_reg);
        force_sat  = (force_full > F_W'(FORCE_MAX));
    end

    // Header is word zero; words one to three are the forces of those channels.
    always_comb
    begin
        word_sel = byte_idx_reg[IDX_W-1:1];
        word_val = '0;
        word_sat = 1'b0;
        if (word_sel == '0)
        begin
            word_val = cfg.header_word;
        end
        else if (int'(word_sel) < NUM_CHANNELS)
        begin
            word_val = force_reg[CH_W'(word_sel)];
            word_sat = clip_reg[CH_W'(word_sel)];
        end
        tx_next.frame_byte = byte_idx_reg[0] ? word_val[WORD_W-1:BYTE_W] : word_val[BYTE_W-1:0];
        tx_next.last_byte  = (byte_idx_reg == IDX_W'(FRAME_LEN - 1));
        tx_next.saturated  = word_sat;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (cmd.kind == CMD_FRAME) ? BK_FRAME : BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                state_next = BK_RATIO;
            end
            BK_RATIO:
            begin
                state_next = (den == '0) ? BK_IDLE : BK_DIV;
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_GAIN;
                end
            end
            BK_GAIN:
            begin
                state_next = BK_IDLE;
            end
            BK_FRAME:
            begin
                if (load && tx_next.last_byte)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        load          = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = ratio_num;
        div_req.den   = den;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !q_empty;
            end
            BK_RATIO:
            begin
                div_req.start = (den != '0);
            end
            BK_FRAME:
            begin
                load = !tx_valid_reg || tx_ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign tx_valid = tx_valid_reg;
    assign tx_data  = tx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            tx_valid_reg <= 1'b0;
            byte_idx_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                force_reg[i] <= '0;
                clip_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                byte_idx_reg <= '0;
            end
            else if (load)
            begin
                byte_idx_reg <= byte_idx_reg + 1'b1;
            end

            if (load)
            begin
                tx_valid_reg <= 1'b1;
            end
            else if (tx_ready)
            begin
                tx_valid_reg <= 1'b0;
            end

            // A zero divider denominator only happens with a zero supply.
            if (state_reg == BK_RATIO && den == '0)
            begin
                force_reg[ch_reg] <= FORCE_MAX;
                clip_reg[ch_reg]  <= 1'b1;
            end
            else if (state_reg == BK_GAIN)
            begin
                force_reg[ch_reg] <= force_sat ? FORCE_MAX : force_full[WORD_W-1:0];
                clip_reg[ch_reg]  <= force_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ch_reg  <= CH_W'(cmd.channel);
            avg_reg <= WORD_W'(avg_prod >> AVG_SHIFT);
        end
        if (state_reg == BK_SCALE)
        begin
            prod_reg <= PROD_W'(avg_reg) * PROD_W'(cfg.supply_millivolts);
        end
        if (state_reg == BK_DIV && div_rsp.done)
        begin
            quot_reg <= div_rsp.quotient;
        end
        if (load)
        begin
            tx_reg <= tx_next;
        end
    end

endmodule

[bench/tb_force_sensor_average_and_frame_unit.sv]
module tb_force_sensor_average_and_frame_unit;

    import fsaf_pkg::*;

    localparam int NUM_CH      = 4;
    localparam int AVG_LEN     = 10;
    localparam int ADC_W       = 12;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 26;
    // A completing block keeps the back end busy through its serial division and up to three
    // can be in flight (two queued, one in work), so this covers any silent work left over.
    localparam int SETTLE      = 250;
    localparam int LIMIT       = 400000;

    // Predicts the frame bytes from the accepted sample and tick transfers.
    class force_frame_model;
        logic [GAIN_W-1:0] gain;
        logic [WORD_W-1:0] supply_mv;
        logic [WORD_W-1:0] header;
        logic [WORD_W-1:0] chan_sum   [NUM_CH];
        logic [3:0]        chan_tally [NUM_CH];
        logic [WORD_W-1:0] chan_force [NUM_CH];
        logic              chan_clip  [NUM_CH];
        tx_t               expected_frame_bytes[$];
        int                errors;
        int                items_taken;
        int                blocks_done;
        int                blocks_clipped;
        int                frames_sent;
        int                bytes_checked;

        function new();
            gain      = GAIN_RESET;
            supply_mv = SUPPLY_RESET;
            header    = HEADER_RESET;
            for (int i = 0; i < NUM_CH; i++)
            begin
                chan_sum[i]   = '0;
                chan_tally[i] = '0;
                chan_force[i] = '0;
                chan_clip[i]  = 1'b0;
            end
            errors         = 0;
            items_taken    = 0;
            blocks_done    = 0;
            blocks_clipped = 0;
            frames_sent    = 0;
            bytes_checked  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] data);
            case (index)
                REG_FORCE_GAIN:  gain      = data[GAIN_W-1:0];
                REG_SUPPLY_MV:   supply_mv = data;
                REG_HEADER_WORD: header    = data;
                default: ;
            endcase
        endfunction

        function void finish_block(int ch);
            longint unsigned avg;
            longint unsigned mv;
            longint unsigned den;
            longint unsigned ratio;
            longint unsigned product;
            avg = chan_sum[ch] / AVG_LEN;
            mv  = (avg * supply_mv) >> ADC_W;
            den = supply_mv - mv;
            blocks_done++;
            // A zero supply leaves the divider with nothing to divide by; it clips.
            if (den == 0)
            begin
                chan_force[ch] = FORCE_MAX;
                chan_clip[ch]  = 1'b1;
            end
            else
            begin
                ratio   = (mv * MV_SCALE) / den;
                product = gain * ratio;
                if (product > FORCE_MAX)
                begin
                    chan_force[ch] = FORCE_MAX;
                    chan_clip[ch]  = 1'b1;
                end
                else
                begin
                    chan_force[ch] = product[WORD_W-1:0];
                    chan_clip[ch]  = 1'b0;
                end
            end
            if (chan_clip[ch])
                blocks_clipped++;
            chan_sum[ch]   = '0;
            chan_tally[ch] = '0;
        endfunction

        function void push_byte(logic [BYTE_W-1:0] value, logic last, logic sat);
            tx_t b;
            b.frame_byte = value;
            b.last_byte  = last;
            b.saturated  = sat;
            expected_frame_bytes.push_back(b);
        endfunction

        function void take_item(item_t it);
            int ch;
            ch = int'(it.channel);
            items_taken++;
            if (it.opcode == OP_SAMPLE)
            begin
                if (ch == 0 || ch >= NUM_CH)
                    return;
                chan_sum[ch]   = chan_sum[ch] + WORD_W'(it.sample);
                chan_tally[ch] = chan_tally[ch] + 1'b1;
                if (chan_tally[ch] >= AVG_LEN)
                    finish_block(ch);
            end
            else
            begin
                frames_sent++;
                push_byte(header[7:0], 1'b0, 1'b0);
                push_byte(header[15:8], 1'b0, 1'b0);
                for (int k = 1; k < 4; k++)
                begin
                    push_byte(chan_force[k][7:0], 1'b0, chan_clip[k]);
                    push_byte(chan_force[k][15:8], k == 3, chan_clip[k]);
                end
            end
        endfunction

        function void check_tx(tx_t got);
            tx_t want;
            if (expected_frame_bytes.size() == 0)
            begin
                $error("tx transfer with no frame byte expected: %0h", got);
                errors++;
                return;
            end
            want = expected_frame_bytes.pop_front();
            bytes_checked++;
            if (got.frame_byte !== want.frame_byte)
            begin
                $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.last_byte !== want.last_byte)
            begin
                $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    item_t                item_data;
    logic                 tx_valid;
    logic                 tx_ready;
    tx_t                  tx_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    force_frame_model model;
    int               send_gap_pct;
    int               recv_stall_pct;
    int               cycles;

    force_sensor_average_and_frame_unit #(
        .NUM_CHANNELS (NUM_CH),
        .AVG_COUNT    (AVG_LEN),
        .ADC_BITS     (ADC_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .tx_valid   (tx_valid),
        .tx_ready   (tx_ready),
        .tx_data    (tx_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_force_sensor_average_and_frame_unit NOT OK");
        $finish;
    end

    // Receiver: per-cycle random stalls at the rate of the current idling mode.
    initial
    begin
        tx_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tx_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_valid && tx_ready)
            model.check_tx(tx_data);
    end

    task automatic send_item(input item_t it);
        if ($urandom_range(99) < send_gap_pct)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item_valid = 1'b1;
        item_data  = it;
        do
            @(posedge clk);
        while (!item_ready);
        model.take_item(it);
        @(negedge clk);
    endtask

    task automatic send_sample(input int ch, input int value);
        item_t it;
        it.opcode  = OP_SAMPLE;
        it.channel = CH_FIELD_W'(ch);
        it.sample  = SAMPLE_W'(value);
        send_item(it);
    endtask

    task automatic send_tick();
        item_t it;
        it.opcode  = OP_TICK;
        it.channel = CH_FIELD_W'($urandom_range(3));
        it.sample  = SAMPLE_W'($urandom);
        send_item(it);
    endtask

    task automatic wait_frames_out();
        item_valid = 1'b0;
        while (model.expected_frame_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        wait_frames_out();
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        model.set_reg(index, data);
        cfg_we = 1'b0;
    endtask

    task automatic send_random_item();
        item_t it;
        int    pick;
        it.channel = CH_FIELD_W'($urandom_range(3));
        it.sample  = SAMPLE_W'($urandom);
        if ($urandom_range(99) < 15)
        begin
            it.opcode = OP_TICK;
        end
        else
        begin
            it.opcode = OP_SAMPLE;
            // Mostly live channels so blocks complete; channel zero now and then.
            if ($urandom_range(9) != 0)
                it.channel = CH_FIELD_W'($urandom_range(1, 3));
            pick = $urandom_range(99);
            if (pick < 20)
                it.sample = SAMPLE_W'($urandom_range(3900, 4095));
            else if (pick < 30)
                it.sample = SAMPLE_W'($urandom_range(0, 200));
            else if (pick < 35)
                it.sample = '0;
        end
        send_item(it);
    endtask

    initial
    begin
        cfg_t phase_regs [PHASES];

        model          = new();
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item_data      = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FORCE_GAIN;
        cfg_data       = '0;
        send_gap_pct   = 30;
        recv_stall_pct = 55;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset settings: a frame before any block has
        // completed, an ignored channel-zero sample, a full-scale block that clips,
        // an all-zero block and a frame that reports them.
        send_tick();
        send_sample(0, 4095);
        for (int i = 0; i < AVG_LEN; i++)
            send_sample(1, 4095);
        for (int i = 0; i < AVG_LEN; i++)
            send_sample(3, 0);
        send_tick();
        wait_idle();

        phase_regs[0] = '{8'd255, 16'd65535, 16'h0000};
        phase_regs[1] = '{8'd0, 16'd1, 16'hFFFF};
        phase_regs[2] = '{8'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom)};
        // A zero supply gives a zero denominator, which skips the divider and clips.
        phase_regs[3] = '{8'($urandom), 16'd0, 16'($urandom)};
        phase_regs[4] = '{8'd1, 16'd4096, 16'($urandom)};
        phase_regs[5] = '{GAIN_RESET, SUPPLY_RESET, HEADER_RESET};

        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_gap_pct   = 30;
                    recv_stall_pct = 55;
                end
                1:
                begin
                    send_gap_pct   = 55;
                    recv_stall_pct = 30;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_reg(REG_FORCE_GAIN, WORD_W'(phase_regs[p].force_gain));
            write_reg(REG_SUPPLY_MV, phase_regs[p].supply_millivolts);
            write_reg(REG_HEADER_WORD, phase_regs[p].header_word);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Halfway through, hold the sender back until the frames are out.
                if (i == PHASE_ITEMS / 2)
                    wait_frames_out();
                send_random_item();
            end
            send_tick();
            wait_idle();
        end

        $display("Covered %0d item transfers, %0d frames, %0d byte checks.",
                 model.items_taken, model.frames_sent, model.bytes_checked);
        $display("Completed %0d averaging blocks, %0d of them clipped, over %0d settings.",
                 model.blocks_done, model.blocks_clipped, PHASES + 1);
        if (model.errors == 0 && model.expected_frame_bytes.size() == 0)
            $display("tb_force_sensor_average_and_frame_unit OK");
        else
            $display("tb_force_sensor_average_and_frame_unit NOT OK");
        $finish;
    end

endmodule

[force_sensor_average_and_frame_unit.f]
hdl/fsaf_pkg.sv
hdl/fsaf_front.sv
hdl/fsaf_queue.sv
hdl/fsaf_div.sv
hdl/fsaf_back.sv
hdl/force_sensor_average_and_frame_unit.sv
bench/tb_force_sensor_average_and_frame_unit.sv
